FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/bce_pkg.sv
// ---------------------------------------------------------------------------
// bce_pkg
// Constants, control word layout and microprogram of the biquad cascade.
// ---------------------------------------------------------------------------
package bce_pkg;

	localparam int BAND_COUNT  = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 32;

	localparam int NUM_COEFS   = 5;
	localparam int BAND_IN_W   = 4;
	localparam int CIDX_W      = 3;
	localparam int COEF_FRAC   = COEF_BITS - 6;
	localparam int STATE_BITS  = 40;
	localparam int STATE_FRAC  = 31;
	localparam int IN_SHIFT    = STATE_FRAC - (SAMPLE_BITS - 1);
	localparam int IN_PAD      = STATE_BITS - SAMPLE_BITS - IN_SHIFT;

	// split of a state operand for the multiplier: unsigned low part, signed high part
	localparam int LO_BITS     = 24;
	localparam int HI_BITS     = STATE_BITS - LO_BITS;
	localparam int MB_W        = LO_BITS + 1;
	localparam int PROD_W      = COEF_BITS + MB_W;
	localparam int FULL_W      = COEF_BITS + STATE_BITS;
	localparam int TERM_W      = FULL_W - COEF_FRAC;
	localparam int ACC_W       = 48;

	localparam int BAND_W      = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int COEF_WORDS  = BAND_COUNT * NUM_COEFS;
	localparam int ADDR_W      = $clog2(COEF_WORDS);

	localparam int STEP_COUNT  = 20;
	localparam int PC_W        = $clog2(STEP_COUNT);
	localparam int DONE_STEP   = STEP_COUNT - 1;

	typedef enum logic {REQ_SAMPLE = 1'b0, REQ_COEF = 1'b1} req_t;

	typedef enum logic [CIDX_W-1:0] {
		CI_B0 = 3'd0, CI_B1 = 3'd1, CI_B2 = 3'd2, CI_A1 = 3'd3, CI_A2 = 3'd4
	} coef_idx_t;

	typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_t;
	typedef enum logic [1:0] {OP_W1, OP_W2, OP_W} opnd_t;
	typedef enum logic [1:0] {FULL_NONE, FULL_LOAD, FULL_ADD} full_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_START, ACC_ADD, ACC_SUB} acc_t;
	typedef enum logic [1:0] {SAT_NONE, SAT_W, SAT_Y} sat_t;
	typedef enum logic [1:0] {SEQ_NEXT, SEQ_BAND_END, SEQ_DONE} seq_t;

	typedef struct packed {
		logic      rd;
		coef_idx_t cidx;
		mul_t      mul;
		opnd_t     opsel;
		full_t     full;
		acc_t      acc;
		sat_t      sat;
		seq_t      seq;
	} uop_t;

	localparam uop_t UOP_NOP = '{rd: 1'b0, cidx: CI_B0, mul: MUL_NONE, opsel: OP_W1,
		full: FULL_NONE, acc: ACC_NONE, sat: SAT_NONE, seq: SEQ_NEXT};

	// Microprogram for one band. Each product takes four steps:
	// read coefficient, low multiply, high multiply, combine; the
	// accumulate of one product overlaps the start of the next.
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = UOP_NOP;
		unique case (pc)
			PC_W'(0): begin
				u.rd = 1'b1; u.cidx = CI_A1; u.acc = ACC_START;
			end
			PC_W'(1): begin
				u.mul = MUL_LO; u.opsel = OP_W1;
			end
			PC_W'(2): begin
				u.mul = MUL_HI; u.opsel = OP_W1; u.full = FULL_LOAD;
			end
			PC_W'(3): begin
				u.rd = 1'b1; u.cidx = CI_A2; u.full = FULL_ADD;
			end
			PC_W'(4): begin
				u.acc = ACC_SUB; u.mul = MUL_LO; u.opsel = OP_W2;
			end
			PC_W'(5): begin
				u.mul = MUL_HI; u.opsel = OP_W2; u.full = FULL_LOAD;
			end
			PC_W'(6): begin
				u.full = FULL_ADD;
			end
			PC_W'(7): begin
				u.acc = ACC_SUB; u.rd = 1'b1; u.cidx = CI_B1;
			end
			PC_W'(8): begin
				u.sat = SAT_W; u.mul = MUL_LO; u.opsel = OP_W1;
			end
			PC_W'(9): begin
				u.mul = MUL_HI; u.opsel = OP_W1; u.full = FULL_LOAD;
			end
			PC_W'(10): begin
				u.full = FULL_ADD; u.rd = 1'b1; u.cidx = CI_B2;
			end
			PC_W'(11): begin
				u.acc = ACC_ADD; u.mul = MUL_LO; u.opsel = OP_W2;
			end
			PC_W'(12): begin
				u.mul = MUL_HI; u.opsel = OP_W2; u.full = FULL_LOAD;
			end
			PC_W'(13): begin
				u.full = FULL_ADD; u.rd = 1'b1; u.cidx = CI_B0;
			end
			PC_W'(14): begin
				u.acc = ACC_ADD; u.mul = MUL_LO; u.opsel = OP_W;
			end
			PC_W'(15): begin
				u.mul = MUL_HI; u.opsel = OP_W; u.full = FULL_LOAD;
			end
			PC_W'(16): begin
				u.full = FULL_ADD;
			end
			PC_W'(17): begin
				u.acc = ACC_ADD;
			end
			PC_W'(18): begin
				u.sat = SAT_Y; u.seq = SEQ_BAND_END;
			end
			default: begin
				u.seq = SEQ_DONE;
			end
		endcase
		return u;
	endfunction

	// clamp the accumulator to the signed state range
	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [ACC_W-1:0] a);
		logic [ACC_W-STATE_BITS:0] top;
		top = a[ACC_W-1:STATE_BITS-1];
		if ((&top) || !(|top)) begin
			return a[STATE_BITS-1:0];
		end else if (a[ACC_W-1]) begin
			return {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

FILE: src/biquad_cascade_equalizer.sv
// ---------------------------------------------------------------------------
// biquad_cascade_equalizer
// Ten-band cascade of direct form II biquads run by a microcoded sequencer
// over one shared 32x25 multiplier.
// ---------------------------------------------------------------------------
// Timing: an audio request runs the program band by band from acceptance
//   to a valid result, the one multiplier doing each of five products in
//   a low and a high half. No request, audio or coefficient, is taken
//   while the program runs; its last step waits for a free output
//   register. A finished result waits in the output register.
// Reset: sequencer idle, delay state zero, every band passes through.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_cascade_equalizer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic signed [bce_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [bce_pkg::BAND_IN_W-1:0]          band,
	input  logic [bce_pkg::CIDX_W-1:0]             coef_index,
	input  logic signed [bce_pkg::COEF_BITS-1:0]   coef_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [bce_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                   clipped
);
	import bce_pkg::*;

	localparam int RND_W = STATE_BITS + 1;
	localparam int TOP_W = RND_W - IN_SHIFT - SAMPLE_BITS + 1;

	// sequencer
	logic                    run_q;
	logic [PC_W-1:0]         pc_q;
	logic [BAND_W-1:0]       band_q;
	logic [ADDR_W-1:0]       base_q;
	uop_t                    uop;
	logic                    last_band;
	logic                    out_free;

	// coefficient store
	logic signed [COEF_BITS-1:0] coef_mem [COEF_WORDS];
	logic                        cvld_q [COEF_WORDS];
	logic signed [COEF_BITS-1:0] coef_rdata_q;
	logic                        coef_hit_q;
	logic                        coef_b0_q;
	logic signed [COEF_BITS-1:0] coef_op;
	logic [ADDR_W-1:0]           rd_addr;
	logic [ADDR_W-1:0]           wr_addr;
	logic                        coef_wr;
	logic                        sample_req;

	// delay state
	logic signed [STATE_BITS-1:0] d1_q [BAND_COUNT];
	logic signed [STATE_BITS-1:0] d2_q [BAND_COUNT];

	// datapath
	logic signed [STATE_BITS-1:0] s_q;
	logic signed [STATE_BITS-1:0] w_q;
	logic signed [STATE_BITS-1:0] w1_q;
	logic signed [STATE_BITS-1:0] w2_q;
	logic signed [STATE_BITS-1:0] opnd;
	logic signed [MB_W-1:0]       mul_b;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [FULL_W-1:0]     full_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      term;

	// output rounding
	logic signed [RND_W-1:0]       rnd;
	logic [TOP_W-1:0]              rnd_top;
	logic signed [SAMPLE_BITS-1:0] res_sample;
	logic                          res_clip;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	// decode the request and the current control word
	assign in_stall   = run_q;
	assign sample_req = in_valid && !in_stall && (req_type == REQ_SAMPLE);
	assign coef_wr    = in_valid && !in_stall && (req_type == REQ_COEF)
		&& (band < BAND_IN_W'(BAND_COUNT)) && (coef_index < CIDX_W'(NUM_COEFS));
	assign wr_addr    = (ADDR_W'(band) << 2) + ADDR_W'(band) + ADDR_W'(coef_index);
	assign uop        = run_q ? ucode(pc_q) : UOP_NOP;
	assign rd_addr    = base_q + ADDR_W'(uop.cidx);
	assign last_band  = (band_q == BAND_W'(BAND_COUNT - 1));
	assign out_free   = !out_valid_q || !out_stall;

	// advance the step counter, jump at band end, finish into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			pc_q        <= '0;
			band_q      <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result, drop it once taken
			if (uop.seq == SEQ_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (sample_req) begin
				run_q  <= 1'b1;
				pc_q   <= '0;
				band_q <= '0;
				base_q <= '0;
			end else if (run_q) begin
				unique case (uop.seq)
					SEQ_NEXT: begin
						pc_q <= pc_q + PC_W'(1);
					end
					SEQ_BAND_END: begin
						if (last_band) begin
							pc_q   <= PC_W'(DONE_STEP);
							band_q <= '0;
							base_q <= '0;
						end else begin
							pc_q   <= '0;
							band_q <= band_q + BAND_W'(1);
							base_q <= base_q + ADDR_W'(NUM_COEFS);
						end
					end
					SEQ_DONE: begin
						if (out_free) begin
							run_q <= 1'b0;
						end
					end
					default: begin
						pc_q <= pc_q;
					end
				endcase
			end
		end
	end

	// write and read the coefficient memory
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[wr_addr] <= coef_value;
		end
		if (uop.rd) begin
			coef_rdata_q <= coef_mem[rd_addr];
		end
	end

	// track written coefficients; an unwritten one reads as the identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_WORDS; i++) begin
				cvld_q[i] <= 1'b0;
			end
			coef_hit_q <= 1'b0;
			coef_b0_q  <= 1'b0;
		end else begin
			if (coef_wr) begin
				cvld_q[wr_addr] <= 1'b1;
			end
			if (uop.rd) begin
				coef_hit_q <= cvld_q[rd_addr];
				coef_b0_q  <= (uop.cidx == CI_B0);
			end
		end
	end

	assign coef_op = coef_hit_q ? coef_rdata_q
		: (coef_b0_q ? COEF_BITS'(64'sd1 <<< COEF_FRAC) : '0);

	// hold delay state; clear a band on a coefficient write, update at band end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_COUNT; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (coef_wr) begin
				d1_q[BAND_W'(band)] <= '0;
				d2_q[BAND_W'(band)] <= '0;
			end else if (uop.sat == SAT_Y) begin
				d1_q[band_q] <= w_q;
				d2_q[band_q] <= w1_q;
			end
		end
	end

	// select the multiplier operand half
	always_comb begin
		unique case (uop.opsel)
			OP_W1:   opnd = w1_q;
			OP_W2:   opnd = w2_q;
			OP_W:    opnd = w_q;
			default: opnd = w1_q;
		endcase
		if (uop.mul == MUL_HI) begin
			mul_b = MB_W'(signed'(opnd[STATE_BITS-1:LO_BITS]));
		end else begin
			mul_b = signed'({1'b0, opnd[LO_BITS-1:0]});
		end
	end

	// rounded product from the combined halves
	assign term = ACC_W'(signed'(full_q[FULL_W-1:COEF_FRAC]));

	// multiply, combine halves, accumulate, saturate
	always_ff @(posedge clk) begin
		if (sample_req) begin
			s_q <= {{IN_PAD{sample_in[SAMPLE_BITS-1]}}, sample_in, {IN_SHIFT{1'b0}}};
		end
		if (uop.mul != MUL_NONE) begin
			prod_s1 <= coef_op * mul_b;
		end
		unique case (uop.full)
			FULL_LOAD: full_q <= FULL_W'(prod_s1);
			FULL_ADD:  full_q <= full_q + (FULL_W'(prod_s1) <<< LO_BITS)
				+ (FULL_W'(1) <<< (COEF_FRAC - 1));
			default:   full_q <= full_q;
		endcase
		unique case (uop.acc)
			ACC_START: begin
				acc_q <= ACC_W'(s_q);
				w1_q  <= d1_q[band_q];
				w2_q  <= d2_q[band_q];
			end
			ACC_ADD:   acc_q <= acc_q + term;
			ACC_SUB:   acc_q <= acc_q - term;
			default: begin
				if (uop.sat == SAT_W) begin
					acc_q <= '0;
				end
			end
		endcase
		if (uop.sat == SAT_W) begin
			w_q <= sat_state(acc_q);
		end else if (uop.sat == SAT_Y) begin
			s_q <= sat_state(acc_q);
		end
	end

	// round the cascade output to the sample format and clamp it
	assign rnd     = RND_W'(s_q) + (RND_W'(1) <<< (IN_SHIFT - 1));
	assign rnd_top = rnd[RND_W-1:IN_SHIFT+SAMPLE_BITS-1];
	always_comb begin
		res_clip = !((&rnd_top) || !(|rnd_top));
		if (!res_clip) begin
			res_sample = rnd[IN_SHIFT+SAMPLE_BITS-1:IN_SHIFT];
		end else if (rnd[RND_W-1]) begin
			res_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// load the output register when the program finishes
	always_ff @(posedge clk) begin
		if (uop.seq == SEQ_DONE && out_free) begin
			sample_out_q <= res_sample;
			clipped_q    <= res_clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// checks on the sequencer
	`ASSERT_CLK(a_start_step, sample_req |=> run_q && (pc_q == '0) && (band_q == '0), "sample request did not start the program")
	`ASSERT_CLK(a_band_range, band_q < BAND_W'(BAND_COUNT), "band counter out of range")
	`ASSERT_CLK(a_base_match, base_q == (ADDR_W'(band_q) << 2) + ADDR_W'(band_q), "coefficient base out of step with band")
	`ASSERT_CLK(a_pc_range, run_q |-> pc_q <= PC_W'(DONE_STEP), "step counter beyond program")

endmodule

FILE: tb/biquad_cascade_equalizer_tb.sv
// ---------------------------------------------------------------------------
// biquad_cascade_equalizer_tb
// Drives audio and coefficient requests into the ten-band biquad cascade,
// predicts every equalized sample with an exact fixed-point model of the
// direct form II sections, and checks each result in order. Both sides
// idle and stall at random, and the receiver holds off once long enough
// to back the block up.
// ---------------------------------------------------------------------------
module biquad_cascade_equalizer_tb;
	import bce_pkg::*;

	localparam int WIDE         = 80;
	localparam int RAND_ITEMS   = 1280;
	localparam int LONG_HOLD    = 1500;
	localparam int DRAIN_CYCLES = 400;
	localparam int LIMIT_CYCLES = 1500000;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_ONE = 32'sd1 <<< COEF_FRAC;
	localparam logic signed [WIDE-1:0] STATE_HI = (80'sd1 <<< (STATE_BITS-1)) - 80'sd1;
	localparam logic signed [WIDE-1:0] STATE_LO = -(80'sd1 <<< (STATE_BITS-1));

	// out-of-range write targets
	localparam logic [BAND_IN_W-1:0] BAND_PAST_END = BAND_IN_W'(BAND_COUNT);
	localparam logic [BAND_IN_W-1:0] BAND_TOP      = '1;
	localparam logic [CIDX_W-1:0]    CIDX_PAST_END = CIDX_W'(NUM_COEFS);
	localparam logic [CIDX_W-1:0]    CIDX_TOP      = '1;

	typedef struct {
		req_t                          kind;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [BAND_IN_W-1:0]          band;
		logic [CIDX_W-1:0]             cidx;
		logic signed [COEF_BITS-1:0]   cval;
	} eq_req_t;

	typedef struct {
		eq_req_t                       req;
		bit                            known;
		logic signed [SAMPLE_BITS-1:0] want;
		logic                          want_clip;
	} stim_row_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          clip;
	} eq_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [BAND_IN_W-1:0] band;
	logic [CIDX_W-1:0] coef_index;
	logic signed [COEF_BITS-1:0] coef_value;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic clipped;

	// predictor state
	logic signed [COEF_BITS-1:0]  band_coef [BAND_COUNT][NUM_COEFS];
	logic signed [STATE_BITS-1:0] band_w1 [BAND_COUNT];
	logic signed [STATE_BITS-1:0] band_w2 [BAND_COUNT];

	eq_result_t pending_samples[$];
	stim_row_t  dir_rows[$];
	int fail_count   = 0;
	int results_seen = 0;
	int sent_count   = 0;
	int cycle_count  = 0;
	bit quiet        = 1'b0;
	bit held_long    = 1'b0;

	biquad_cascade_equalizer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.sample_in  (sample_in),
		.band       (band),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	always #5 clk = ~clk;

	// coefficient times state, rounded half up to the state scale
	function automatic logic signed [WIDE-1:0] scaled_product(
		input logic signed [COEF_BITS-1:0] c, input logic signed [WIDE-1:0] s);
		logic signed [WIDE-1:0] cw;
		logic signed [WIDE-1:0] p;
		cw = c;
		p = cw * s + (80'sd1 <<< (COEF_FRAC-1));
		return p >>> COEF_FRAC;
	endfunction

	function automatic logic signed [WIDE-1:0] clamp_state(input logic signed [WIDE-1:0] x);
		if (x > STATE_HI) begin
			return STATE_HI;
		end else if (x < STATE_LO) begin
			return STATE_LO;
		end
		return x;
	endfunction

	// apply one request to the predictor; return 1 when it yields a sample
	function automatic bit eq_process(input eq_req_t r, output eq_result_t res);
		logic signed [WIDE-1:0] s, w, y, w1, w2, rnd;
		res.value = '0;
		res.clip  = 1'b0;
		if (r.kind == REQ_COEF) begin
			if (r.band < BAND_COUNT && r.cidx < NUM_COEFS) begin
				band_coef[r.band][r.cidx] = r.cval;
				band_w1[r.band] = '0;
				band_w2[r.band] = '0;
			end
			return 1'b0;
		end
		s = r.smp;
		s = s <<< IN_SHIFT;
		for (int b = 0; b < BAND_COUNT; b++) begin
			w1 = band_w1[b];
			w2 = band_w2[b];
			w = clamp_state(s - scaled_product(band_coef[b][CI_A1], w1)
				- scaled_product(band_coef[b][CI_A2], w2));
			y = clamp_state(scaled_product(band_coef[b][CI_B0], w)
				+ scaled_product(band_coef[b][CI_B1], w1)
				+ scaled_product(band_coef[b][CI_B2], w2));
			band_w2[b] = w1[STATE_BITS-1:0];
			band_w1[b] = w[STATE_BITS-1:0];
			s = y;
		end
		rnd = (s + (80'sd1 <<< (IN_SHIFT-1))) >>> IN_SHIFT;
		if (rnd > SMP_MAX) begin
			res.value = SMP_MAX;
			res.clip  = 1'b1;
		end else if (rnd < SMP_MIN) begin
			res.value = SMP_MIN;
			res.clip  = 1'b1;
		end else begin
			res.value = rnd[SAMPLE_BITS-1:0];
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t audio_row(input logic signed [SAMPLE_BITS-1:0] v,
		input bit known, input logic signed [SAMPLE_BITS-1:0] want, input logic want_clip);
		stim_row_t row;
		row.req.kind  = REQ_SAMPLE;
		row.req.smp   = v;
		row.req.band  = '0;
		row.req.cidx  = CI_B0;
		row.req.cval  = '0;
		row.known     = known;
		row.want      = want;
		row.want_clip = want_clip;
		return row;
	endfunction

	function automatic stim_row_t coef_row(input logic [BAND_IN_W-1:0] b,
		input logic [CIDX_W-1:0] idx, input logic signed [COEF_BITS-1:0] val);
		stim_row_t row;
		row.req.kind  = REQ_COEF;
		row.req.smp   = '0;
		row.req.band  = b;
		row.req.cidx  = idx;
		row.req.cval  = val;
		row.known     = 1'b0;
		row.want      = '0;
		row.want_clip = 1'b0;
		return row;
	endfunction

	// offer one request starting at a falling edge; return at the falling
	// edge after it is taken
	task automatic offer(input stim_row_t row);
		eq_result_t res;
		if (!quiet && (sent_count / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= row.req.kind;
		sample_in  <= row.req.smp;
		band       <= row.req.band;
		coef_index <= row.req.cidx;
		coef_value <= row.req.cval;
		do @(posedge clk); while (in_stall);
		sent_count++;
		if (eq_process(row.req, res)) begin
			if (row.known) begin
				res.value = row.want;
				res.clip  = row.want_clip;
			end
			pending_samples.push_back(res);
		end
		@(negedge clk);
	endtask

	// check each delivered sample against the oldest prediction
	always @(posedge clk) begin
		eq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample_out %0d, clipped %0b with nothing pending",
					$time, sample_out, clipped);
				fail_count++;
			end else begin
				want = pending_samples.pop_front();
				if (sample_out !== want.value) begin
					$display("%0t: sample_out mismatch: expected %0d, actual %0d",
						$time, want.value, sample_out);
					fail_count++;
				end
				if (clipped !== want.clip) begin
					$display("%0t: clipped mismatch: expected %0b, actual %0b",
						$time, want.clip, clipped);
					fail_count++;
				end
			end
		end
	end

	// stall the output side: one long hold early on, then random bursts
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held_long && results_seen >= 40) begin
				out_stall <= 1'b1;
				held_long = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet && (results_seen / 16) % 3 != 2
				&& $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int placed;
		int pick;
		logic [BAND_IN_W-1:0] nb;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_SAMPLE;
		sample_in  = '0;
		band       = '0;
		coef_index = '0;
		coef_value = '0;
		out_stall  = 1'b0;

		// predictor after reset: every band passes through
		for (int b = 0; b < BAND_COUNT; b++) begin
			for (int k = 0; k < NUM_COEFS; k++) begin
				band_coef[b][k] = '0;
			end
			band_coef[b][CI_B0] = COEF_ONE;
			band_w1[b] = '0;
			band_w2[b] = '0;
		end

		// identity cascade: output equals input
		dir_rows.push_back(audio_row(16'sd0, 1'b1, 16'sd0, 1'b0));
		dir_rows.push_back(audio_row(SMP_MAX, 1'b1, SMP_MAX, 1'b0));
		dir_rows.push_back(audio_row(SMP_MIN, 1'b1, SMP_MIN, 1'b0));
		dir_rows.push_back(audio_row(16'sd1, 1'b1, 16'sd1, 1'b0));
		dir_rows.push_back(audio_row(-16'sd1, 1'b1, -16'sd1, 1'b0));
		// gain of two in band 0: extremes clip, small values double
		dir_rows.push_back(coef_row(4'd0, CI_B0, COEF_ONE <<< 1));
		dir_rows.push_back(audio_row(SMP_MAX, 1'b1, SMP_MAX, 1'b1));
		dir_rows.push_back(audio_row(SMP_MIN, 1'b1, SMP_MIN, 1'b1));
		dir_rows.push_back(audio_row(16'sd100, 1'b1, 16'sd200, 1'b0));
		// writes to a missing band or coefficient are dropped
		dir_rows.push_back(coef_row(BAND_PAST_END, CI_B0, '0));
		dir_rows.push_back(coef_row(BAND_TOP, CI_B1, COEF_MAX));
		dir_rows.push_back(coef_row(4'd3, CIDX_PAST_END, '0));
		dir_rows.push_back(coef_row(4'd3, CIDX_TOP, COEF_MIN));
		dir_rows.push_back(audio_row(16'sd100, 1'b1, 16'sd200, 1'b0));
		dir_rows.push_back(coef_row(4'd0, CI_B0, COEF_ONE));
		// extreme coefficients drive band 9 into internal saturation
		dir_rows.push_back(coef_row(4'd9, CI_B1, COEF_MAX));
		dir_rows.push_back(coef_row(4'd9, CI_A1, COEF_MIN));
		dir_rows.push_back(audio_row(SMP_MAX, 1'b0, '0, 1'b0));
		dir_rows.push_back(audio_row(SMP_MIN, 1'b0, '0, 1'b0));
		dir_rows.push_back(audio_row(16'sd12345, 1'b0, '0, 1'b0));
		dir_rows.push_back(coef_row(4'd4, CI_B2, COEF_ONE >>> 1));
		dir_rows.push_back(coef_row(4'd4, CI_A2, -(COEF_ONE >>> 2)));
		dir_rows.push_back(audio_row(-16'sd20000, 1'b0, '0, 1'b0));
		dir_rows.push_back(coef_row(4'd9, CI_A1, '0));
		dir_rows.push_back(coef_row(4'd9, CI_B1, '0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			offer(dir_rows[i]);
		end

		// random traffic: mostly samples, with whole-band reprogramming
		// and an occasional stray write
		placed = 0;
		while (placed < RAND_ITEMS) begin
			quiet = (placed >= RAND_ITEMS - 80);
			pick = $urandom_range(0, 99);
			row.known     = 1'b0;
			row.want      = '0;
			row.want_clip = 1'b0;
			row.req.smp   = SAMPLE_BITS'($urandom);
			row.req.band  = BAND_IN_W'($urandom);
			row.req.cidx  = CIDX_W'($urandom);
			row.req.cval  = COEF_BITS'($urandom);
			if (pick < 5) begin
				// load a stable section with moderate gain into one band
				nb = BAND_IN_W'($urandom_range(0, BAND_COUNT - 1));
				for (int k = 0; k < NUM_COEFS; k++) begin
					row.req.kind = REQ_COEF;
					row.req.band = nb;
					row.req.cidx = CIDX_W'(k);
					if (k == CI_B0) begin
						row.req.cval = COEF_BITS'((1 << (COEF_FRAC - 1))
							+ $urandom_range(0, 1 << COEF_FRAC));
					end else if (k == CI_A2) begin
						row.req.cval = COEF_BITS'($urandom_range(0, 1 << (COEF_FRAC - 1))
							- (1 << (COEF_FRAC - 2)));
					end else begin
						row.req.cval = COEF_BITS'($urandom_range(0, 1 << COEF_FRAC)
							- (1 << (COEF_FRAC - 1)));
					end
					offer(row);
					placed++;
				end
			end else if (pick < 9) begin
				row.req.kind = REQ_COEF;
				offer(row);
				if (row.req.band < BAND_COUNT && row.req.cidx < NUM_COEFS) begin
					placed++;
				end
			end else begin
				row.req.kind = REQ_SAMPLE;
				if (pick < 40) begin
					row.req.smp = SAMPLE_BITS'($urandom_range(0, 4095) - 2048);
				end
				offer(row);
				placed++;
			end
		end
		in_valid <= 1'b0;

		// drain the remaining samples, then let the pipeline settle
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_samples.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/bce_pkg.sv
src/biquad_cascade_equalizer.sv
tb/biquad_cascade_equalizer_tb.sv
